[design/iat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indent-aware tokenizer package
// Token kinds, byte codes, scan modes, controller commands and keyword table.
// ----------------------------------------------------------------------------
package iat_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int KW_COUNT    = 16;

    typedef logic [5:0]  t_kind;
    typedef logic [23:0] t_off;
    typedef logic [15:0] t_len;
    typedef logic [23:0] t_line;
    typedef logic [7:0]  t_byte;
    typedef logic [6:0]  t_cnt;
    typedef logic [15:0] t_level;

    localparam t_kind K_END       = 6'd0;
    localparam t_kind K_IDENT     = 6'd1;
    localparam t_kind K_NUMBER    = 6'd2;
    localparam t_kind K_STRING    = 6'd3;
    localparam t_kind K_INDENT    = 6'd4;
    localparam t_kind K_DEDENT    = 6'd5;
    localparam t_kind K_IF        = 6'd6;
    localparam t_kind K_ELSE      = 6'd7;
    localparam t_kind K_ELIF      = 6'd8;
    localparam t_kind K_TRUE      = 6'd9;
    localparam t_kind K_FALSE     = 6'd10;
    localparam t_kind K_NONE      = 6'd11;
    localparam t_kind K_AND       = 6'd12;
    localparam t_kind K_OR        = 6'd13;
    localparam t_kind K_NOT       = 6'd14;
    localparam t_kind K_WHILE     = 6'd15;
    localparam t_kind K_FUNCTION  = 6'd16;
    localparam t_kind K_RETURN    = 6'd17;
    localparam t_kind K_BREAK     = 6'd18;
    localparam t_kind K_CONTINUE  = 6'd19;
    localparam t_kind K_LPAREN    = 6'd20;
    localparam t_kind K_RPAREN    = 6'd21;
    localparam t_kind K_COMMA     = 6'd22;
    localparam t_kind K_ASSIGN    = 6'd23;
    localparam t_kind K_EQ        = 6'd24;
    localparam t_kind K_NE        = 6'd25;
    localparam t_kind K_LT        = 6'd26;
    localparam t_kind K_LE        = 6'd27;
    localparam t_kind K_GT        = 6'd28;
    localparam t_kind K_GE        = 6'd29;
    localparam t_kind K_PLUS      = 6'd30;
    localparam t_kind K_MINUS     = 6'd31;
    localparam t_kind K_STAR      = 6'd32;
    localparam t_kind K_SLASH     = 6'd33;
    localparam t_kind K_PERCENT   = 6'd34;
    localparam t_kind K_LBRACK    = 6'd35;
    localparam t_kind K_RBRACK    = 6'd36;
    localparam t_kind K_TOO_DEEP  = 6'd37;
    localparam t_kind K_INCONSIST = 6'd38;
    localparam t_kind K_STRAY     = 6'd39;

    localparam t_byte CH_TAB     = 8'h09;
    localparam t_byte CH_LF      = 8'h0A;
    localparam t_byte CH_CR      = 8'h0D;
    localparam t_byte CH_SPACE   = 8'h20;
    localparam t_byte CH_BANG    = 8'h21;
    localparam t_byte CH_QUOTE   = 8'h22;
    localparam t_byte CH_PERCENT = 8'h25;
    localparam t_byte CH_LPAREN  = 8'h28;
    localparam t_byte CH_RPAREN  = 8'h29;
    localparam t_byte CH_STAR    = 8'h2A;
    localparam t_byte CH_PLUS    = 8'h2B;
    localparam t_byte CH_COMMA   = 8'h2C;
    localparam t_byte CH_MINUS   = 8'h2D;
    localparam t_byte CH_SLASH   = 8'h2F;
    localparam t_byte CH_ZERO    = 8'h30;
    localparam t_byte CH_NINE    = 8'h39;
    localparam t_byte CH_LT      = 8'h3C;
    localparam t_byte CH_EQ      = 8'h3D;
    localparam t_byte CH_GT      = 8'h3E;
    localparam t_byte CH_UP_A    = 8'h41;
    localparam t_byte CH_UP_Z    = 8'h5A;
    localparam t_byte CH_LBRACK  = 8'h5B;
    localparam t_byte CH_RBRACK  = 8'h5D;
    localparam t_byte CH_UNDER   = 8'h5F;
    localparam t_byte CH_LO_A    = 8'h61;
    localparam t_byte CH_LO_Z    = 8'h7A;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_OPER
    } t_mode;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_FLUSH,
        OP_END,
        OP_DECIDE,
        OP_WALK,
        OP_WCMP,
        OP_BURST,
        OP_PLAIN,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic adv;
    } t_cmd;

    typedef struct packed {
        logic room;
        logic eos;
        logic halted;
        logic scan_done;
        logic lead;
        logic gt;
        logic lt;
        logic full;
        logic walk_more;
        logic res_ok;
        logic k_zero;
    } t_stat;

    typedef struct packed {
        t_kind kind;
        t_off  offset;
        t_len  length;
        t_line line;
    } t_token;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  len;
        t_kind       kind;
    } t_kw;

    localparam t_kw KW_TABLE [KW_COUNT] = '{
        '{64'h6966,             4'd2, K_IF},
        '{64'h656C7365,         4'd4, K_ELSE},
        '{64'h656C6966,         4'd4, K_ELIF},
        '{64'h74727565,         4'd4, K_TRUE},
        '{64'h66616C7365,       4'd5, K_FALSE},
        '{64'h6E6F6E65,         4'd4, K_NONE},
        '{64'h616E64,           4'd3, K_AND},
        '{64'h6F72,             4'd2, K_OR},
        '{64'h6E6F74,           4'd3, K_NOT},
        '{64'h7768696C65,       4'd5, K_WHILE},
        '{64'h66756E6374696F6E, 4'd8, K_FUNCTION},
        '{64'h646566,           4'd3, K_FUNCTION},
        '{64'h66756E,           4'd3, K_FUNCTION},
        '{64'h72657475726E,     4'd6, K_RETURN},
        '{64'h627265616B,       4'd5, K_BREAK},
        '{64'h636F6E74696E7565, 4'd8, K_CONTINUE}
    };

    function automatic logic is_alpha(input t_byte b);
        return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
               (b == CH_UNDER);
    endfunction

    function automatic logic is_digit(input t_byte b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic t_kind kw_kind(input logic [63:0] prefix, input logic [3:0] len);
        t_kind k;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (KW_TABLE[i].len == len && KW_TABLE[i].word == prefix) begin
                k = KW_TABLE[i].kind;
            end
        end
        return k;
    endfunction

    function automatic t_kind single_kind(input t_byte op);
        t_kind k;
        case (op)
            CH_EQ:   k = K_ASSIGN;
            CH_LT:   k = K_LT;
            CH_GT:   k = K_GT;
            default: k = K_STRAY;
        endcase
        return k;
    endfunction

    function automatic t_kind double_kind(input t_byte op);
        t_kind k;
        case (op)
            CH_EQ:   k = K_EQ;
            CH_BANG: k = K_NE;
            CH_LT:   k = K_LE;
            default: k = K_GE;
        endcase
        return k;
    endfunction

    function automatic t_kind punct_kind(input t_byte b);
        t_kind k;
        case (b)
            CH_LPAREN:  k = K_LPAREN;
            CH_RPAREN:  k = K_RPAREN;
            CH_COMMA:   k = K_COMMA;
            CH_PLUS:    k = K_PLUS;
            CH_MINUS:   k = K_MINUS;
            CH_STAR:    k = K_STAR;
            CH_SLASH:   k = K_SLASH;
            CH_PERCENT: k = K_PERCENT;
            CH_LBRACK:  k = K_LBRACK;
            CH_RBRACK:  k = K_RBRACK;
            default:    k = K_STRAY;
        endcase
        return k;
    endfunction

endpackage

[design/iat_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer source channel
// Valid/ready channel carrying one source byte or the end marker per word.
// ----------------------------------------------------------------------------
interface iat_in_if;
    logic                valid;
    logic                ready;
    iat_pkg::t_byte      source_byte;
    logic                end_of_source;

    modport source (output valid, output source_byte, output end_of_source, input ready);
    modport sink   (input valid, input source_byte, input end_of_source, output ready);
endinterface

[design/iat_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer token channel
// Valid/ready channel carrying one token per word.
// ----------------------------------------------------------------------------
interface iat_out_if;
    logic                valid;
    logic                ready;
    iat_pkg::t_kind      token_kind;
    iat_pkg::t_off       token_offset;
    iat_pkg::t_len       token_length;
    iat_pkg::t_line      token_line;
    logic                last_of_run;

    modport source (output valid, output token_kind, output token_offset,
                    output token_length, output token_line, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_offset,
                    input token_length, input token_line, input last_of_run,
                    output ready);
endinterface

[design/iat_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer controller
// Sequences load, scan, end marker, indent decision, stack walk, dedent burst, classify and finish steps.
// ----------------------------------------------------------------------------
module iat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  iat_pkg::t_stat  i_stat,
    output iat_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_END,
        S_DECIDE,
        S_WALK,
        S_WCMP,
        S_BURST,
        S_PLAIN,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_adv, n_adv;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_adv     = r_adv;
        o_cmd.op  = iat_pkg::OP_NONE;
        o_cmd.adv = r_adv;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = iat_pkg::OP_LOAD;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.room) begin
                    if (i_stat.eos) begin
                        o_cmd.op = iat_pkg::OP_FLUSH;
                        n_adv    = 1'b0;
                        n_state  = S_END;
                    end else if (i_stat.halted) begin
                        n_adv   = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        o_cmd.op = iat_pkg::OP_SCAN;
                        n_adv    = 1'b1;
                        if (i_stat.scan_done) begin
                            n_state = S_FIN;
                        end else if (i_stat.lead) begin
                            n_state = S_DECIDE;
                        end else begin
                            n_state = S_PLAIN;
                        end
                    end
                end
            end
            S_END: begin
                if (i_stat.room) begin
                    o_cmd.op = iat_pkg::OP_END;
                    n_state  = S_FIN;
                end
            end
            S_DECIDE: begin
                if (i_stat.room) begin
                    o_cmd.op = iat_pkg::OP_DECIDE;
                    if (i_stat.lt) begin
                        n_state = S_WALK;
                    end else if (i_stat.gt && i_stat.full) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_PLAIN;
                    end
                end
            end
            S_WALK: begin
                o_cmd.op = iat_pkg::OP_WALK;
                n_state  = S_WCMP;
            end
            S_WCMP: begin
                if (i_stat.room) begin
                    o_cmd.op = iat_pkg::OP_WCMP;
                    if (i_stat.walk_more) begin
                        n_state = S_WALK;
                    end else if (!i_stat.res_ok) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_BURST;
                    end
                end
            end
            S_BURST: begin
                if (i_stat.k_zero) begin
                    n_state = S_PLAIN;
                end else if (i_stat.room) begin
                    o_cmd.op = iat_pkg::OP_BURST;
                end
            end
            S_PLAIN: begin
                if (i_stat.room) begin
                    o_cmd.op = iat_pkg::OP_PLAIN;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.room) begin
                    o_cmd.op = iat_pkg::OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_adv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_adv   <= n_adv;
        end
    end

    a_walk_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> (r_state == S_WCMP))
        else $error("stack read not followed by compare");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == iat_pkg::OP_LOAD) |=> !o_in_ready)
        else $error("input taken while a word is in progress");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == iat_pkg::OP_FINISH) |=> o_in_ready)
        else $error("finish step did not return to idle");

endmodule

[design/iat_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer datapath
// Scan state, indentation stack memory, token hold stage and output register.
// ----------------------------------------------------------------------------
module iat_dp #(
    parameter int INDENT_DEPTH = 64,
    parameter int OFFSET_BITS  = 24,
    parameter int LENGTH_BITS  = 16,
    parameter int LINE_BITS    = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iat_pkg::t_cmd     i_cmd,
    output iat_pkg::t_stat    o_stat,
    input  iat_pkg::t_byte    i_byte,
    input  logic              i_eos,
    iat_out_if.source         o_out
);

    localparam int DW = $clog2(INDENT_DEPTH + 1);
    localparam int AW = $clog2(INDENT_DEPTH);

    iat_pkg::t_byte          r_byte, n_byte;
    logic                    r_eos, n_eos;
    iat_pkg::t_mode          r_mode, n_mode;
    iat_pkg::t_byte          r_op_byte, n_op_byte;
    logic [63:0]             r_prefix, n_prefix;
    logic [OFFSET_BITS-1:0]  r_start, n_start;
    logic [LENGTH_BITS-1:0]  r_size, n_size;
    logic [OFFSET_BITS-1:0]  r_pos, n_pos;
    logic [LINE_BITS-1:0]    r_line, n_line;
    logic                    r_lstart, n_lstart;
    iat_pkg::t_level         r_space, n_space;
    logic                    r_halted, n_halted;
    logic [DW-1:0]           r_depth, n_depth;
    logic [DW-1:0]           r_t, n_t;
    logic [DW-1:0]           r_k, n_k;
    iat_pkg::t_cnt           r_cnt, n_cnt;

    iat_pkg::t_level         r_mem [INDENT_DEPTH];
    iat_pkg::t_level         r_rd;
    logic                    r_rd_zero;
    logic                    mem_we;
    logic                    rd_en;
    logic [DW-1:0]           rd_addr;
    iat_pkg::t_level         level;

    iat_pkg::t_token         r_hold, n_hold;
    logic                    r_hold_v, n_hold_v;
    iat_pkg::t_token         r_out;
    logic                    r_out_v;
    logic                    r_out_last;
    logic                    push;
    logic                    push_last;
    logic                    out_free;

    logic                    e_want;
    logic                    emit_fire;
    iat_pkg::t_kind          e_kind;
    logic [OFFSET_BITS-1:0]  e_off;
    logic [LENGTH_BITS-1:0]  e_len;
    iat_pkg::t_kind          flush_kind;
    logic                    more;

    logic [OFFSET_BITS-1:0]  pos_inc;
    logic [LENGTH_BITS-1:0]  size_inc;
    logic [LINE_BITS-1:0]    line_inc;
    iat_pkg::t_level         space_inc;

    assign pos_inc   = (r_pos == '1) ? r_pos : r_pos + 1'b1;
    assign size_inc  = (r_size == '1) ? r_size : r_size + 1'b1;
    assign line_inc  = (r_line == '1) ? r_line : r_line + 1'b1;
    assign space_inc = (r_space == '1) ? r_space : r_space + 1'b1;

    assign level    = r_rd_zero ? '0 : r_rd;
    assign out_free = !r_out_v || o_out.ready;

    assign more = (r_mode == iat_pkg::MODE_IDENT)
                ? (iat_pkg::is_alpha(r_byte) || iat_pkg::is_digit(r_byte))
                : iat_pkg::is_digit(r_byte);

    always_comb begin
        case (r_mode)
            iat_pkg::MODE_IDENT:
                flush_kind = iat_pkg::kw_kind(r_prefix,
                    (r_size <= LENGTH_BITS'(8)) ? r_size[3:0] : 4'd0);
            iat_pkg::MODE_NUMBER: flush_kind = iat_pkg::K_NUMBER;
            iat_pkg::MODE_STRING: flush_kind = iat_pkg::K_STRING;
            default:              flush_kind = iat_pkg::single_kind(r_op_byte);
        endcase
    end

    always_comb begin
        o_stat.room      = !r_hold_v || out_free;
        o_stat.eos       = r_eos;
        o_stat.halted    = r_halted;
        o_stat.scan_done = 1'b0;
        o_stat.lead      = 1'b0;
        case (r_mode)
            iat_pkg::MODE_IDENT, iat_pkg::MODE_NUMBER: o_stat.scan_done = more;
            iat_pkg::MODE_STRING: o_stat.scan_done = 1'b1;
            iat_pkg::MODE_OPER:   o_stat.scan_done = (r_byte == iat_pkg::CH_EQ);
            default: begin
                if (r_lstart) begin
                    if (r_byte == iat_pkg::CH_SPACE || r_byte == iat_pkg::CH_LF) begin
                        o_stat.scan_done = 1'b1;
                    end else begin
                        o_stat.lead = 1'b1;
                    end
                end
            end
        endcase
        o_stat.gt        = r_space > level;
        o_stat.lt        = r_space < level;
        o_stat.full      = r_depth >= DW'(INDENT_DEPTH);
        o_stat.walk_more = (r_t != DW'(1)) && (r_space < level);
        o_stat.res_ok    = r_space == level;
        o_stat.k_zero    = r_k == '0;
    end

    always_comb begin
        n_byte    = r_byte;
        n_eos     = r_eos;
        n_mode    = r_mode;
        n_op_byte = r_op_byte;
        n_prefix  = r_prefix;
        n_start   = r_start;
        n_size    = r_size;
        n_pos     = r_pos;
        n_line    = r_line;
        n_lstart  = r_lstart;
        n_space   = r_space;
        n_halted  = r_halted;
        n_depth   = r_depth;
        n_t       = r_t;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_hold    = r_hold;
        n_hold_v  = r_hold_v;
        e_want    = 1'b0;
        e_kind    = iat_pkg::K_END;
        e_off     = r_start;
        e_len     = r_size;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_depth - 1'b1;
        push      = 1'b0;
        push_last = 1'b0;
        case (i_cmd.op)
            iat_pkg::OP_LOAD: begin
                n_byte = i_byte;
                n_eos  = i_eos;
                n_cnt  = '0;
            end
            iat_pkg::OP_SCAN: begin
                case (r_mode)
                    iat_pkg::MODE_IDENT, iat_pkg::MODE_NUMBER: begin
                        if (more) begin
                            if (r_mode == iat_pkg::MODE_IDENT && r_size < LENGTH_BITS'(8)) begin
                                n_prefix = {r_prefix[55:0], r_byte};
                            end
                            n_size = size_inc;
                        end else begin
                            e_want = 1'b1;
                            e_kind = flush_kind;
                            n_mode = iat_pkg::MODE_IDLE;
                        end
                    end
                    iat_pkg::MODE_STRING: begin
                        n_size = size_inc;
                        if (r_byte == iat_pkg::CH_QUOTE) begin
                            e_want = 1'b1;
                            e_kind = iat_pkg::K_STRING;
                            e_len  = size_inc;
                            n_mode = iat_pkg::MODE_IDLE;
                        end else if (r_byte == iat_pkg::CH_LF) begin
                            n_line = line_inc;
                        end
                    end
                    iat_pkg::MODE_OPER: begin
                        e_want = 1'b1;
                        n_mode = iat_pkg::MODE_IDLE;
                        if (r_byte == iat_pkg::CH_EQ) begin
                            n_size = LENGTH_BITS'(2);
                            e_kind = iat_pkg::double_kind(r_op_byte);
                            e_len  = LENGTH_BITS'(2);
                        end else begin
                            e_kind = flush_kind;
                        end
                    end
                    default: begin
                        if (r_lstart) begin
                            if (r_byte == iat_pkg::CH_SPACE) begin
                                n_space = space_inc;
                                n_size  = size_inc;
                            end else if (r_byte == iat_pkg::CH_LF) begin
                                n_line  = line_inc;
                                n_space = '0;
                                n_start = pos_inc;
                                n_size  = '0;
                            end else begin
                                n_lstart = 1'b0;
                                rd_en    = 1'b1;
                            end
                        end
                    end
                endcase
            end
            iat_pkg::OP_FLUSH: begin
                if (!r_halted && r_mode != iat_pkg::MODE_IDLE) begin
                    e_want = 1'b1;
                    e_kind = flush_kind;
                end
            end
            iat_pkg::OP_END: begin
                e_want    = 1'b1;
                e_kind    = iat_pkg::K_END;
                e_off     = r_pos;
                e_len     = '0;
                n_mode    = iat_pkg::MODE_IDLE;
                n_op_byte = '0;
                n_prefix  = '0;
                n_start   = '0;
                n_size    = '0;
                n_pos     = '0;
                n_line    = LINE_BITS'(1);
                n_lstart  = 1'b1;
                n_space   = '0;
                n_halted  = 1'b0;
                n_depth   = DW'(1);
            end
            iat_pkg::OP_DECIDE: begin
                if (r_space > level) begin
                    e_want = 1'b1;
                    if (r_depth >= DW'(INDENT_DEPTH)) begin
                        e_kind   = iat_pkg::K_TOO_DEEP;
                        n_halted = 1'b1;
                    end else begin
                        e_kind  = iat_pkg::K_INDENT;
                        mem_we  = 1'b1;
                        n_depth = r_depth + 1'b1;
                    end
                end else if (r_space < level) begin
                    n_t = r_depth - 1'b1;
                end
            end
            iat_pkg::OP_WALK: begin
                rd_en   = 1'b1;
                rd_addr = r_t - 1'b1;
            end
            iat_pkg::OP_WCMP: begin
                if (r_t != DW'(1) && r_space < level) begin
                    n_t = r_t - 1'b1;
                end else if (r_space != level) begin
                    e_want   = 1'b1;
                    e_kind   = iat_pkg::K_INCONSIST;
                    n_halted = 1'b1;
                end else begin
                    e_want  = 1'b1;
                    e_kind  = iat_pkg::K_DEDENT;
                    n_depth = r_t;
                    n_k     = r_depth - r_t - 1'b1;
                end
            end
            iat_pkg::OP_BURST: begin
                e_want = 1'b1;
                e_kind = iat_pkg::K_DEDENT;
                e_off  = r_pos;
                e_len  = '0;
                n_k    = r_k - 1'b1;
            end
            iat_pkg::OP_PLAIN: begin
                if (r_byte == iat_pkg::CH_SPACE || r_byte == iat_pkg::CH_TAB ||
                    r_byte == iat_pkg::CH_CR) begin
                    n_mode = r_mode;
                end else if (r_byte == iat_pkg::CH_LF) begin
                    n_line   = line_inc;
                    n_lstart = 1'b1;
                    n_space  = '0;
                    n_start  = pos_inc;
                    n_size   = '0;
                end else if (iat_pkg::is_alpha(r_byte)) begin
                    n_mode   = iat_pkg::MODE_IDENT;
                    n_start  = r_pos;
                    n_size   = LENGTH_BITS'(1);
                    n_prefix = 64'(r_byte);
                end else if (iat_pkg::is_digit(r_byte)) begin
                    n_mode  = iat_pkg::MODE_NUMBER;
                    n_start = r_pos;
                    n_size  = LENGTH_BITS'(1);
                end else if (r_byte == iat_pkg::CH_QUOTE) begin
                    n_mode  = iat_pkg::MODE_STRING;
                    n_start = r_pos;
                    n_size  = LENGTH_BITS'(1);
                end else if (r_byte == iat_pkg::CH_EQ || r_byte == iat_pkg::CH_BANG ||
                             r_byte == iat_pkg::CH_LT || r_byte == iat_pkg::CH_GT) begin
                    n_mode    = iat_pkg::MODE_OPER;
                    n_start   = r_pos;
                    n_size    = LENGTH_BITS'(1);
                    n_op_byte = r_byte;
                end else begin
                    e_want = 1'b1;
                    e_kind = iat_pkg::punct_kind(r_byte);
                    e_off  = r_pos;
                    e_len  = LENGTH_BITS'(1);
                end
            end
            iat_pkg::OP_FINISH: begin
                if (r_hold_v) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_hold_v  = 1'b0;
                end
                if (i_cmd.adv) begin
                    n_pos = pos_inc;
                end
            end
            default: n_cnt = r_cnt;
        endcase

        emit_fire = e_want && (r_cnt < iat_pkg::t_cnt'(iat_pkg::MAX_RESULTS));
        if (emit_fire) begin
            n_cnt       = r_cnt + 1'b1;
            push        = r_hold_v;
            n_hold_v    = 1'b1;
            n_hold.kind   = e_kind;
            n_hold.offset = iat_pkg::t_off'(e_off);
            n_hold.length = iat_pkg::t_len'(e_len);
            n_hold.line   = iat_pkg::t_line'(r_line);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_depth[AW-1:0]] <= r_space;
        end
        if (rd_en) begin
            r_rd      <= r_mem[rd_addr[AW-1:0]];
            r_rd_zero <= (rd_addr == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_eos     <= n_eos;
        r_op_byte <= n_op_byte;
        r_t       <= n_t;
        r_k       <= n_k;
        r_hold    <= n_hold;
        if (push) begin
            r_out      <= r_hold;
            r_out_last <= push_last;
        end
        if (!i_rst_n) begin
            r_mode   <= iat_pkg::MODE_IDLE;
            r_prefix <= '0;
            r_start  <= '0;
            r_size   <= '0;
            r_pos    <= '0;
            r_line   <= LINE_BITS'(1);
            r_lstart <= 1'b1;
            r_space  <= '0;
            r_halted <= 1'b0;
            r_depth  <= DW'(1);
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_prefix <= n_prefix;
            r_start  <= n_start;
            r_size   <= n_size;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_lstart <= n_lstart;
            r_space  <= n_space;
            r_halted <= n_halted;
            r_depth  <= n_depth;
            r_cnt    <= n_cnt;
            r_hold_v <= n_hold_v;
            if (push) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.token_kind   = r_out.kind;
    assign o_out.token_offset = r_out.offset;
    assign o_out.token_length = r_out.length;
    assign o_out.token_line   = r_out.line;
    assign o_out.last_of_run  = r_out_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("token pushed over a stalled output word");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_depth != '0 && r_depth <= DW'(INDENT_DEPTH)))
        else $error("indent depth out of range");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_cnt <= iat_pkg::t_cnt'(iat_pkg::MAX_RESULTS)))
        else $error("token count per word over cap");

    a_finish_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == iat_pkg::OP_FINISH) |=> !r_hold_v)
        else $error("held token left after finish");

endmodule

[design/indent_aware_tokenizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indent-aware tokenizer
// Streaming lexer for indentation-structured source text.
//
// i_in carries one source byte, or the end marker, per word; o_out carries
// one token per word, and last_of_run flags the final token of each input
// word. Inputs that produce no token produce no output word.
// A byte that opens or ends a token passes through load, scan, classify and
// finish before the next ready. A byte that extends an open token or
// string, a leading space or newline, and any byte while halted skip the
// classify step. The first visible byte of a line adds an indent decision
// step on the indent stack read; a dedent adds a read and a compare step per
// stack level walked, a burst step per extra DEDENT and a step to leave the
// burst. The end marker takes load, scan, end and finish. The controller
// handles one word at a time; the registered stack read sets the walk rate.
// Tokens pass through a hold stage and an output register; when o_out is
// stalled the block finishes its current word up to the point where both
// are full, then waits. Reset empties both stages and returns the scanner to
// line one, offset zero, one indentation level; no memory clearing is needed.
// ----------------------------------------------------------------------------
module indent_aware_tokenizer_top #(
    parameter int INDENT_DEPTH = 64,
    parameter int OFFSET_BITS  = 24,
    parameter int LENGTH_BITS  = 16,
    parameter int LINE_BITS    = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iat_in_if.sink    i_in,
    iat_out_if.source o_out
);

    iat_pkg::t_cmd  cmd;
    iat_pkg::t_stat stat;
    logic           in_ready;

    assign i_in.ready = in_ready;

    iat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    iat_dp #(
        .INDENT_DEPTH (INDENT_DEPTH),
        .OFFSET_BITS  (OFFSET_BITS),
        .LENGTH_BITS  (LENGTH_BITS),
        .LINE_BITS    (LINE_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_byte  (i_in.source_byte),
        .i_eos   (i_in.end_of_source),
        .o_out   (o_out)
    );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indent-aware tokenizer testbench
// Streams source bytes and end markers into the tokenizer and checks every
// token against a local lexer model with its own indentation stack.
// Directed rows cover keywords, two-byte operators, lone bang, stray bytes,
// strings across lines, indent/dedent and inconsistent indentation. Random
// programs of indented lines follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NO_KIND    = -1;
    localparam int STACK_MAX  = 64;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [23:0] OFF_MAX  = 24'hFFFFFF;
    localparam logic [15:0] LEN_MAX  = 16'hFFFF;

    typedef struct {
        iat_pkg::t_kind kind;
        iat_pkg::t_off  offset;
        iat_pkg::t_len  length;
        iat_pkg::t_line line;
        logic           last;
    } t_expect;

    typedef struct {
        iat_pkg::t_byte b;
        logic           eos;
        int             want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    iat_in_if  in_ch ();
    iat_out_if out_ch ();

    indent_aware_tokenizer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_expect token_q[$];
    int      err_count;
    int      idle_cycles;
    int      sink_stall;
    bit      quiet;

    // lexer state
    iat_pkg::t_level lvl_stack[STACK_MAX];
    int              lvl_depth;
    bit              line_head;
    logic [15:0]     lead_spaces;
    iat_pkg::t_mode  mode;
    iat_pkg::t_byte  op_byte;
    logic [63:0]     word_bits;
    iat_pkg::t_off   tok_start;
    iat_pkg::t_len   tok_size;
    iat_pkg::t_off   byte_pos;
    iat_pkg::t_line  line_no;
    bit              stopped;
    int              step_count;

    string kw_text[16] = '{"if", "else", "elif", "true", "false", "none", "and", "or",
                           "not", "while", "function", "def", "fun", "return", "break",
                           "continue"};
    iat_pkg::t_kind kw_code[16] = '{
        iat_pkg::K_IF, iat_pkg::K_ELSE, iat_pkg::K_ELIF, iat_pkg::K_TRUE,
        iat_pkg::K_FALSE, iat_pkg::K_NONE, iat_pkg::K_AND, iat_pkg::K_OR,
        iat_pkg::K_NOT, iat_pkg::K_WHILE, iat_pkg::K_FUNCTION, iat_pkg::K_FUNCTION,
        iat_pkg::K_FUNCTION, iat_pkg::K_RETURN, iat_pkg::K_BREAK, iat_pkg::K_CONTINUE
    };

    initial i_clk = 1'b0;

    always #2 i_clk = ~i_clk;

    task automatic report(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void lexer_reset();
        foreach (lvl_stack[i]) lvl_stack[i] = '0;
        lvl_depth     = 1;
        line_head     = 1'b1;
        lead_spaces   = '0;
        mode          = iat_pkg::MODE_IDLE;
        op_byte       = '0;
        word_bits     = '0;
        tok_start     = '0;
        tok_size      = '0;
        byte_pos      = '0;
        line_no       = 24'd1;
        stopped       = 1'b0;
    endfunction

    function automatic void add_token(input iat_pkg::t_kind k, input iat_pkg::t_off off,
                                      input iat_pkg::t_len len);
        t_expect e;
        if (step_count >= iat_pkg::MAX_RESULTS) return;
        e.kind   = k;
        e.offset = off;
        e.length = len;
        e.line   = line_no;
        e.last   = 1'b0;
        token_q.push_back(e);
        step_count++;
    endfunction

    function automatic iat_pkg::t_kind word_code();
        logic [63:0] p;
        foreach (kw_text[i]) begin
            if (tok_size == kw_text[i].len()) begin
                p = '0;
                for (int j = 0; j < kw_text[i].len(); j++) p = (p << 8) | kw_text[i][j];
                if (p == word_bits) return kw_code[i];
            end
        end
        return iat_pkg::K_IDENT;
    endfunction

    function automatic iat_pkg::t_kind lone_op(input iat_pkg::t_byte op);
        case (op)
            iat_pkg::CH_EQ: return iat_pkg::K_ASSIGN;
            iat_pkg::CH_LT: return iat_pkg::K_LT;
            iat_pkg::CH_GT: return iat_pkg::K_GT;
            default:        return iat_pkg::K_STRAY;
        endcase
    endfunction

    function automatic iat_pkg::t_kind pair_op(input iat_pkg::t_byte op);
        case (op)
            iat_pkg::CH_EQ:   return iat_pkg::K_EQ;
            iat_pkg::CH_BANG: return iat_pkg::K_NE;
            iat_pkg::CH_LT:   return iat_pkg::K_LE;
            default:          return iat_pkg::K_GE;
        endcase
    endfunction

    function automatic bit letter(input iat_pkg::t_byte b);
        return (b >= iat_pkg::CH_LO_A && b <= iat_pkg::CH_LO_Z) ||
               (b >= iat_pkg::CH_UP_A && b <= iat_pkg::CH_UP_Z) ||
               b == iat_pkg::CH_UNDER;
    endfunction

    function automatic bit digit(input iat_pkg::t_byte b);
        return b >= iat_pkg::CH_ZERO && b <= iat_pkg::CH_NINE;
    endfunction

    function automatic void close_token();
        iat_pkg::t_kind k;
        if (mode == iat_pkg::MODE_IDLE) return;
        case (mode)
            iat_pkg::MODE_IDENT:  k = word_code();
            iat_pkg::MODE_NUMBER: k = iat_pkg::K_NUMBER;
            iat_pkg::MODE_STRING: k = iat_pkg::K_STRING;
            default:              k = lone_op(op_byte);
        endcase
        add_token(k, tok_start, tok_size);
        mode = iat_pkg::MODE_IDLE;
    endfunction

    function automatic void open_token(input iat_pkg::t_mode m, input iat_pkg::t_off pos);
        mode      = m;
        tok_start = pos;
        tok_size  = 16'd1;
    endfunction

    function automatic void start_line(input iat_pkg::t_off pos);
        if (line_no != OFF_MAX) line_no++;
        line_head     = 1'b1;
        lead_spaces   = '0;
        tok_start     = (pos != OFF_MAX) ? pos + 24'd1 : pos;
        tok_size      = '0;
    endfunction

    function automatic void judge_indent();
        iat_pkg::t_level cur;
        int              t;
        int              k;
        cur = lvl_stack[lvl_depth - 1];
        if (lead_spaces > cur) begin
            if (lvl_depth >= STACK_MAX) begin
                add_token(iat_pkg::K_TOO_DEEP, tok_start, tok_size);
                stopped = 1'b1;
                return;
            end
            lvl_stack[lvl_depth] = lead_spaces;
            lvl_depth++;
            add_token(iat_pkg::K_INDENT, tok_start, tok_size);
        end else if (lead_spaces < cur) begin
            t = lvl_depth;
            while (t > 1 && lead_spaces < lvl_stack[t - 1]) t--;
            if (lead_spaces != lvl_stack[t - 1]) begin
                add_token(iat_pkg::K_INCONSIST, tok_start, tok_size);
                stopped = 1'b1;
                return;
            end
            k = lvl_depth - t;
            lvl_depth = t;
            add_token(iat_pkg::K_DEDENT, tok_start, tok_size);
            for (; k > 1; k--) add_token(iat_pkg::K_DEDENT, byte_pos, '0);
        end
    endfunction

    function automatic void plain(input iat_pkg::t_byte b, input iat_pkg::t_off pos);
        iat_pkg::t_kind k;
        if (b == iat_pkg::CH_SPACE || b == iat_pkg::CH_TAB || b == iat_pkg::CH_CR) return;
        if (b == iat_pkg::CH_LF) begin
            start_line(pos);
            return;
        end
        if (letter(b)) begin
            open_token(iat_pkg::MODE_IDENT, pos);
            word_bits = {56'd0, b};
            return;
        end
        if (digit(b)) begin
            open_token(iat_pkg::MODE_NUMBER, pos);
            return;
        end
        if (b == iat_pkg::CH_QUOTE) begin
            open_token(iat_pkg::MODE_STRING, pos);
            return;
        end
        if (b == iat_pkg::CH_EQ || b == iat_pkg::CH_BANG || b == iat_pkg::CH_LT ||
            b == iat_pkg::CH_GT) begin
            open_token(iat_pkg::MODE_OPER, pos);
            op_byte = b;
            return;
        end
        case (b)
            iat_pkg::CH_LPAREN:  k = iat_pkg::K_LPAREN;
            iat_pkg::CH_RPAREN:  k = iat_pkg::K_RPAREN;
            iat_pkg::CH_COMMA:   k = iat_pkg::K_COMMA;
            iat_pkg::CH_PLUS:    k = iat_pkg::K_PLUS;
            iat_pkg::CH_MINUS:   k = iat_pkg::K_MINUS;
            iat_pkg::CH_STAR:    k = iat_pkg::K_STAR;
            iat_pkg::CH_SLASH:   k = iat_pkg::K_SLASH;
            iat_pkg::CH_PERCENT: k = iat_pkg::K_PERCENT;
            iat_pkg::CH_LBRACK:  k = iat_pkg::K_LBRACK;
            iat_pkg::CH_RBRACK:  k = iat_pkg::K_RBRACK;
            default:             k = iat_pkg::K_STRAY;
        endcase
        add_token(k, pos, 16'd1);
    endfunction

    function automatic void lex_word(input iat_pkg::t_byte b, input logic eos);
        bit            done;
        bit            more;
        iat_pkg::t_off pos;
        done = 1'b0;
        pos  = byte_pos;
        step_count = 0;
        if (eos) begin
            if (!stopped) close_token();
            add_token(iat_pkg::K_END, pos, '0);
            token_q[token_q.size() - 1].last = 1'b1;
            lexer_reset();
            return;
        end
        if (stopped) return;
        if (mode == iat_pkg::MODE_IDENT || mode == iat_pkg::MODE_NUMBER) begin
            more = (mode == iat_pkg::MODE_IDENT) ? (letter(b) || digit(b)) : digit(b);
            if (more) begin
                if (mode == iat_pkg::MODE_IDENT && tok_size < 8)
                    word_bits = (word_bits << 8) | b;
                if (tok_size != LEN_MAX) tok_size++;
                done = 1'b1;
            end else begin
                close_token();
            end
        end else if (mode == iat_pkg::MODE_STRING) begin
            if (tok_size != LEN_MAX) tok_size++;
            if (b == iat_pkg::CH_QUOTE) close_token();
            else if (b == iat_pkg::CH_LF && line_no != OFF_MAX) line_no++;
            done = 1'b1;
        end else if (mode == iat_pkg::MODE_OPER) begin
            if (b == iat_pkg::CH_EQ) begin
                tok_size = 16'd2;
                add_token(pair_op(op_byte), tok_start, tok_size);
                mode = iat_pkg::MODE_IDLE;
                done = 1'b1;
            end else begin
                close_token();
            end
        end
        if (!done && line_head) begin
            if (b == iat_pkg::CH_SPACE) begin
                if (lead_spaces != 16'hFFFF) lead_spaces++;
                if (tok_size != LEN_MAX) tok_size++;
                done = 1'b1;
            end else if (b == iat_pkg::CH_LF) begin
                start_line(pos);
                done = 1'b1;
            end else begin
                line_head = 1'b0;
                judge_indent();
                if (stopped) done = 1'b1;
            end
        end
        if (!done) plain(b, pos);
        if (byte_pos != OFF_MAX) byte_pos++;
        if (step_count > 0) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    function automatic int gap_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(input iat_pkg::t_byte b, input logic eos, input int want);
        int g;
        int base;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.source_byte   <= b;
        in_ch.end_of_source <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        base = token_q.size();
        lex_word(b, eos);
        if (want != NO_KIND) begin
            if (token_q.size() <= base) report($sformatf("row byte %h gave no token", b));
            else if (token_q[base].kind != iat_pkg::t_kind'(want))
                report($sformatf("row byte %h kind %0d, typed %0d", b, token_q[base].kind,
                                 want));
        end
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0, NO_KIND);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (token_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // random program of indented lines with mostly well-formed tokens
    task automatic send_program(output int sent);
        string  vocab[$];
        int     levels[$];
        int     lines;
        int     ind;
        int     r;
        string  s;
        vocab = '{"if", "else", "elif", "true", "false", "none", "and", "or", "not",
                  "while", "function", "def", "fun", "return", "break", "continue",
                  "foo", "_x9", "continuex", "Ab", "12345", "0", "\"s t\"", "\"a\nb\"",
                  "==", "!=", "<=", ">=", "=", "<", ">", "!", "(", ")", ",", "+", "-",
                  "*", "/", "%", "[", "]", "\t", "\r"};
        levels = '{0};
        sent = 0;
        lines = $urandom_range(2, 8);
        for (int l = 0; l < lines; l++) begin
            r = $urandom_range(0, 99);
            if (r < 45) ind = levels[$];
            else if (r < 70) begin
                ind = levels[$] + $urandom_range(1, 4);
                levels.push_back(ind);
            end else if (r < 92) begin
                levels = levels[0:$urandom_range(0, levels.size() - 1)];
                ind = levels[$];
            end else ind = $urandom_range(0, 10);
            s = "";
            for (int i = 0; i < ind; i++) s = {s, " "};
            if ($urandom_range(0, 9) == 0) s = {s, "\n"};
            else begin
                for (int t = $urandom_range(1, 5); t > 0; t--) begin
                    if ($urandom_range(0, 9) == 0) s = {s, string'(byte'($urandom_range(0, 255)))};
                    else s = {s, vocab[$urandom_range(0, vocab.size() - 1)]};
                    if ($urandom_range(0, 3) != 0) s = {s, " "};
                end
                s = {s, "\n"};
            end
            send_text(s);
            sent += s.len();
        end
        send_word(iat_pkg::t_byte'($urandom_range(0, 255)), 1'b1, NO_KIND);
        sent++;
    endtask

    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            out_ch.ready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) sink_stall <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (token_q.size() == 0) begin
                report($sformatf("token kind %0d with none expected", out_ch.token_kind));
            end else begin
                if (out_ch.token_kind != token_q[0].kind)
                    report($sformatf("kind %0d, want %0d", out_ch.token_kind,
                                     token_q[0].kind));
                if (out_ch.token_offset != token_q[0].offset)
                    report($sformatf("offset %0d, want %0d", out_ch.token_offset,
                                     token_q[0].offset));
                if (out_ch.token_length != token_q[0].length)
                    report($sformatf("length %0d, want %0d", out_ch.token_length,
                                     token_q[0].length));
                if (out_ch.token_line != token_q[0].line)
                    report($sformatf("line %0d, want %0d", out_ch.token_line,
                                     token_q[0].line));
                if (out_ch.last_of_run != token_q[0].last)
                    report($sformatf("last %0b, want %0b", out_ch.last_of_run,
                                     token_q[0].last));
                void'(token_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        int   sent;
        int   total;
        rows = '{
            '{8'h00, 1'b1, iat_pkg::K_END},
            '{"i", 1'b0, NO_KIND}, '{"f", 1'b0, NO_KIND}, '{" ", 1'b0, iat_pkg::K_IF},
            '{"!", 1'b0, NO_KIND}, '{"x", 1'b0, iat_pkg::K_STRAY},
            '{"\n", 1'b0, iat_pkg::K_IDENT},
            '{" ", 1'b0, NO_KIND}, '{" ", 1'b0, NO_KIND}, '{"9", 1'b0, iat_pkg::K_INDENT},
            '{"\n", 1'b0, iat_pkg::K_NUMBER}, '{"a", 1'b0, iat_pkg::K_DEDENT},
            '{">", 1'b0, iat_pkg::K_IDENT},
            '{"=", 1'b0, iat_pkg::K_GE}, '{8'hFF, 1'b0, iat_pkg::K_STRAY},
            '{8'h00, 1'b0, iat_pkg::K_STRAY},
            '{"\"", 1'b0, NO_KIND}, '{"\n", 1'b0, NO_KIND},
            '{8'h55, 1'b1, iat_pkg::K_STRING},
            '{" ", 1'b0, NO_KIND}, '{" ", 1'b0, NO_KIND}, '{"a", 1'b0, iat_pkg::K_INDENT},
            '{"\n", 1'b0, iat_pkg::K_IDENT}, '{" ", 1'b0, NO_KIND},
            '{"b", 1'b0, iat_pkg::K_INCONSIST},
            '{"c", 1'b0, NO_KIND}, '{8'hAA, 1'b1, iat_pkg::K_END}
        };
        err_count   = 0;
        sink_stall  = 0;
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.source_byte   = '0;
        in_ch.end_of_source = 1'b0;
        out_ch.ready = 1'b0;
        lexer_reset();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) send_word(rows[i].b, rows[i].eos, rows[i].want);

        total = 0;
        while (total < 250) begin
            quiet = ($urandom_range(0, 4) == 0);
            send_program(sent);
            total += sent;
            if (total > 125 && total - sent <= 125) drain();
        end
        quiet = 1'b0;

        send_word(8'h00, 1'b1, NO_KIND);
        in_ch.valid <= 1'b0;

        while (token_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (err_count == 0 && token_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
